FILE: sv/bmorph_pkg.sv
// ----------------------------------------------------------------------------
// bmorph_pkg
// Shared types and constants for the 3x3 binary erosion / dilation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmorph_pkg;

  // Default frame size limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_ADDR_W-1:0] REG_MASK_BITS    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DILATE_MODE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd3;

  // Field widths
  localparam int PIX_W    = 8;
  localparam int MASK_W   = 9;
  localparam int FW_W     = 11;
  localparam int FH_W     = 13;
  localparam int OROW_W   = 12;
  localparam int OCOL_W   = 10;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Only this value counts as foreground; results are this or zero
  localparam logic [PIX_W-1:0] SET_VALUE = 8'hFF;

  // Keep the left two columns of the window after a right shift
  localparam logic [MASK_W-1:0] SHIFT_KEEP = 9'h0DB;

  // Reset values of the registers
  localparam logic [MASK_W-1:0] MASK_RST   = 9'h1FF;
  localparam logic [FW_W-1:0]   FW_RST     = 11'd512;
  localparam logic [FH_W-1:0]   FH_RST     = 13'd512;

  typedef struct packed {
    logic [MASK_W-1:0] mask_bits;
    logic              dilate_mode;
    logic [FW_W-1:0]   frame_width;
    logic [FH_W-1:0]   frame_height;
  } cfg_t;

  // One pixel on its way through the window stage
  typedef struct packed {
    logic [OROW_W-1:0] row;     // centre row
    logic [OCOL_W-1:0] col;     // centre column
    logic              bit_new; // incoming pixel is set
    logic              emit;    // a result is produced
    logic              inner;   // centre lies off the frame border
    logic              last;    // last result of the frame
  } item_t;

endpackage

FILE: sv/bmorph_cfg.sv
// ----------------------------------------------------------------------------
// bmorph_cfg
// Configuration register file: decode index, hold mask, mode and frame size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmorph_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bmorph_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bmorph_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output bmorph_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mask_bits    <= bmorph_pkg::MASK_RST;
      cfg.dilate_mode  <= 1'b0;
      cfg.frame_width  <= bmorph_pkg::FW_RST;
      cfg.frame_height <= bmorph_pkg::FH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bmorph_pkg::REG_MASK_BITS: begin
          cfg.mask_bits <= cfg_wdata[bmorph_pkg::MASK_W-1:0];
        end
        bmorph_pkg::REG_DILATE_MODE: begin
          cfg.dilate_mode <= cfg_wdata[0];
        end
        bmorph_pkg::REG_FRAME_WIDTH: begin
          cfg.frame_width <= cfg_wdata[bmorph_pkg::FW_W-1:0];
        end
        bmorph_pkg::REG_FRAME_HEIGHT: begin
          cfg.frame_height <= cfg_wdata[bmorph_pkg::FH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/bmorph_line_store.sv
// ----------------------------------------------------------------------------
// bmorph_line_store
// Two one-bit line stores kept side by side in one 2-bit wide memory.
// Bit 0 holds the previous row, bit 1 the row before that. Registered read
// with forwarding of a write to the same column in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmorph_line_store #(
  parameter int DEPTH = bmorph_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  output logic [1:0]    rd_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] mem_q;
  logic       fwd;
  logic [1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // The memory returns old data on a same-cycle collision: take the write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_data : mem_q;

  a_fwd_on_collision: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr_en && (wr_addr == rd_addr) |=> rd_data == $past(wr_data))
    else $error("line store read missed a same-cycle write");

endmodule

FILE: sv/bmorph_window.sv
// ----------------------------------------------------------------------------
// bmorph_window
// 3x3 window shift register, masked erosion / dilation and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmorph_window (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  bmorph_pkg::item_t                     item,
  input  logic                                  top_bit,
  input  logic                                  mid_bit,
  input  logic [bmorph_pkg::MASK_W-1:0]         mask_bits,
  input  logic                                  dilate_mode,
  input  logic                                  m_tready,
  output logic                                  m_tvalid,
  output logic [bmorph_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                  m_tlast
);

  logic [bmorph_pkg::MASK_W-1:0] window_bits;
  logic [bmorph_pkg::MASK_W-1:0] window_next;
  logic [bmorph_pkg::MASK_W-1:0] hit;
  logic                          on;
  logic [bmorph_pkg::PIX_W-1:0]  pix;
  logic [bmorph_pkg::OROW_W-1:0] out_row;
  logic [bmorph_pkg::OCOL_W-1:0] out_col;
  logic [bmorph_pkg::PIX_W-1:0]  out_pixel;

  always_comb begin
    window_next = ((window_bits >> 1) & bmorph_pkg::SHIFT_KEEP)
                | {6'b0, top_bit, 2'b0}
                | {3'b0, mid_bit, 5'b0}
                | {item.bit_new, 8'b0};
    hit = window_next & mask_bits;
    on  = dilate_mode ? (hit != '0) : (hit == mask_bits);
    pix = (item.inner && on) ? bmorph_pkg::SET_VALUE : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
      m_tvalid    <= 1'b0;
    end else if (adv) begin
      window_bits <= window_next;
      m_tvalid    <= item.emit;
    end else if (m_tready) begin
      m_tvalid    <= 1'b0;
    end
  end

  // Payload: load on advance, hold otherwise
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel <= pix;
      out_row   <= item.row;
      out_col   <= item.col;
      m_tlast   <= item.last;
    end
  end

  assign m_tdata = {2'b0, out_col, out_row, out_pixel};

  a_done_is_inner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> out_row != '0 && out_col != '0)
    else $error("frame end flagged on a border centre");

  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    adv && !item.inner |=> out_pixel == '0)
    else $error("border centre gave a set result");

endmodule

FILE: sv/binary_erode_dilate_3x3.sv
// ----------------------------------------------------------------------------
// binary_erode_dilate_3x3
// Streaming 3x3 binary erosion / dilation over a raster of 8-bit pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless the output side stalls and, once
// it has seen pixel (r, c) with r and c at least 1, returns one result for the
// window centre (r-1, c-1); border centres give 0, the last row and column are
// never emitted, and tlast marks the result for centre (H-2, W-2). Only pixel
// value 255 counts as set. Throughput is one pixel per clock while the output
// side does not stall: each column of the two line stores is read on acceptance
// and written back as the pixel leaves the read stage (the next cycle unless the
// output side stalls) through the single read / single write line memory, with
// same-column collisions forwarded. Each result passes the memory read stage,
// then the output register, which also buffers one result while the output
// side stalls. The input is not ready during reset. The line memory is not
// cleared after reset; its stale content only ever reaches border centres.
`timescale 1ns / 1ps

module binary_erode_dilate_3x3 #(
  parameter int MAX_WIDTH  = bmorph_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmorph_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // pixel input
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [bmorph_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] pixel_value
  input  logic                                 s_tuser,   // frame_start
  // result output
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [7:0] out_pixel, [19:8] out_row, [29:20] out_col, [31:30] zero
  output logic [bmorph_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                                 m_tlast,   // frame_done
  // configuration
  input  logic                                 cfg_we,
  input  logic [bmorph_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bmorph_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  bmorph_pkg::cfg_t  cfg;
  bmorph_pkg::item_t s1_item;
  bmorph_pkg::item_t item_next;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] s1_addr;
  logic          s1_valid;
  logic          s1_adv;
  logic          accept;
  logic [1:0]    rd_data;

  logic [31:0] w32, h32, c32, r32, cm1, rm1;

  bmorph_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  // Clamp the frame size, place the pixel and step the raster counters
  always_comb begin
    w32 = 32'(cfg.frame_width);
    h32 = 32'(cfg.frame_height);
    priority if (w32 < 32'd3) w32 = 32'd3;
    else if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    else w32 = w32;
    priority if (h32 < 32'd3) h32 = 32'd3;
    else if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
    else h32 = h32;

    c32 = (s_tuser || 32'(col) >= w32) ? 32'd0 : 32'(col);
    r32 = (s_tuser || 32'(row) >= h32) ? 32'd0 : 32'(row);
    cm1 = c32 - 32'd1;
    rm1 = r32 - 32'd1;

    item_next.row     = rm1[bmorph_pkg::OROW_W-1:0];
    item_next.col     = cm1[bmorph_pkg::OCOL_W-1:0];
    item_next.bit_new = (s_tdata[bmorph_pkg::PIX_W-1:0] == bmorph_pkg::SET_VALUE);
    item_next.emit    = (r32 >= 32'd1) && (c32 >= 32'd1);
    item_next.inner   = (r32 >= 32'd2) && (c32 >= 32'd2);
    item_next.last    = (r32 == h32 - 32'd1) && (c32 == w32 - 32'd1);

    if (c32 + 32'd1 >= w32) begin
      col_next = '0;
      row_next = (r32 + 32'd1 >= h32) ? '0 : RW'(r32 + 32'd1);
    end else begin
      col_next = CW'(c32 + 32'd1);
      row_next = RW'(r32);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else if (accept) begin
      col      <= col_next;
      row      <= row_next;
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item_next;
      s1_addr <= c32[CW-1:0];
    end
  end

  // Shift the column down: previous row moves to the older store
  bmorph_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (c32[CW-1:0]),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data ({rd_data[0], s1_item.bit_new}),
    .rd_data (rd_data)
  );

  bmorph_window u_window (
    .clk         (clk),
    .rst         (rst),
    .adv         (s1_adv),
    .item        (s1_item),
    .top_bit     (rd_data[1]),
    .mid_bit     (rd_data[0]),
    .mask_bits   (cfg.mask_bits),
    .dilate_mode (cfg.dilate_mode),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    accept |-> !s1_valid || s1_adv)
    else $error("held pixel overwritten before it advanced");

  a_inner_emits: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_item.inner |-> s1_item.emit)
    else $error("inner centre without a result");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> 32'(col) < 32'(MAX_WIDTH))
    else $error("column counter beyond the line store");

endmodule
